// ===== design/gibs_pkg.sv =====
package gibs_pkg;

    localparam int COORD_W    = 13;
    localparam int LEN_W      = 12;
    localparam int AREA_W     = 24;
    localparam int INTER_W    = 24;
    localparam int UNI_W      = 25;
    localparam int THR_W      = 9;
    localparam int IDX_W      = 10;
    localparam int CMP_W      = UNI_W + THR_W;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_PAD_W  = OUT_DATA_W - IDX_W - 2;

    localparam logic [THR_W-1:0] THR_RESET = 9'd115;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [LEN_W-1:0]          w;
        logic [LEN_W-1:0]          h;
    } t_box;

    typedef struct packed {
        logic               vld;
        t_box               cand;
        logic [AREA_W-1:0]  area;
        logic               sup;
        logic               act;
        logic [INTER_W-1:0] inter;
        logic [UNI_W-1:0]   uni;
    } t_flow;

    function automatic logic iou_over(input logic [INTER_W-1:0] inter,
                                      input logic [UNI_W-1:0] uni,
                                      input logic [THR_W-1:0] thr);
        logic [CMP_W-1:0] lhs;
        logic [CMP_W-1:0] rhs;
        lhs = {2'b00, inter, 8'h00};
        rhs = CMP_W'(uni) * CMP_W'(thr);
        return lhs > rhs;
    endfunction

    function automatic logic [LEN_W-1:0] overlap(input logic signed [COORD_W-1:0] a0,
                                                 input logic [LEN_W-1:0] alen,
                                                 input logic signed [COORD_W-1:0] b0,
                                                 input logic [LEN_W-1:0] blen);
        logic signed [COORD_W:0] lo;
        logic signed [COORD_W:0] ae;
        logic signed [COORD_W:0] be;
        logic signed [COORD_W:0] hi;
        logic signed [COORD_W:0] d;
        lo = (a0 > b0) ? {a0[COORD_W-1], a0} : {b0[COORD_W-1], b0};
        ae = {a0[COORD_W-1], a0} + $signed((COORD_W+1)'(alen));
        be = {b0[COORD_W-1], b0} + $signed((COORD_W+1)'(blen));
        hi = (ae < be) ? ae : be;
        d  = hi - lo;
        return (hi > lo) ? LEN_W'(d) : '0;
    endfunction

endpackage

// ===== design/gibs_cell.sv =====
module gibs_cell #(
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [gibs_pkg::THR_W-1:0]         i_thr,
    input  logic [CNT_W-1:0]                   i_kept_cnt,
    input  logic                               i_wr_en,
    input  gibs_pkg::t_box                     i_wr_box,
    input  logic [gibs_pkg::AREA_W-1:0]        i_wr_area,
    input  gibs_pkg::t_flow                    i_flow,
    output gibs_pkg::t_flow                    o_flow
);

    gibs_pkg::t_box                      r_box;
    logic [gibs_pkg::AREA_W-1:0]         r_area;
    gibs_pkg::t_flow                     r_flow;
    gibs_pkg::t_flow                     n_flow;
    logic [gibs_pkg::LEN_W-1:0]          w_iw;
    logic [gibs_pkg::LEN_W-1:0]          w_ih;
    logic [gibs_pkg::INTER_W-1:0]        w_inter;

    always_comb begin
        w_iw    = gibs_pkg::overlap(i_flow.cand.x, i_flow.cand.w, r_box.x, r_box.w);
        w_ih    = gibs_pkg::overlap(i_flow.cand.y, i_flow.cand.h, r_box.y, r_box.h);
        w_inter = gibs_pkg::INTER_W'(w_iw) * gibs_pkg::INTER_W'(w_ih);
        n_flow       = i_flow;
        n_flow.sup   = i_flow.sup
                     | (i_flow.act & gibs_pkg::iou_over(i_flow.inter, i_flow.uni, i_thr));
        n_flow.act   = (i_kept_cnt > CNT_W'(IDX));
        n_flow.inter = w_inter;
        n_flow.uni   = gibs_pkg::UNI_W'(i_flow.area) + gibs_pkg::UNI_W'(r_area)
                     - gibs_pkg::UNI_W'(w_inter);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow <= '0;
        end else begin
            r_flow <= n_flow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_kept_cnt == CNT_W'(IDX))) begin
            r_box  <= i_wr_box;
            r_area <= i_wr_area;
        end
    end

    assign o_flow = r_flow;

endmodule

// ===== design/greedy_iou_box_suppression.sv =====
// Greedy IoU non-maximum suppression over boxes sorted by falling score.
// The slave stream takes one box per request: tdata holds x, y, width and
// height, and tlast marks the last box of a frame. The master stream returns
// one result per box: tdata holds keep, the box index and store_full, and
// tlast echoes the end of the frame. The threshold is written on the cfg
// channel, which is always ready, and the user must write it only while no
// box is in flight; the block itself does not enforce this. Each box walks
// a row of MAX_KEPT cells, one cell per cycle, each cell holding one kept
// box and testing it against the passing box. A box is registered on
// acceptance, and the next box is accepted only after its result is issued.
// A kept box is written into the next free cell when its result is issued.
// Reset clears the kept count, the box index counter and the threshold to
// its default of 115; it is synchronous. When the receiver stalls, a
// finished result waits in the output register while the next box is
// accepted and processed; that box then waits before its result is issued.
module greedy_iou_box_suppression #(
    parameter int MAX_KEPT  = 64,
    parameter int MAX_BOXES = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // rect_x, rect_y, rect_width, rect_height, zero padding
    input  logic [gibs_pkg::IN_DATA_W-1:0]        i_s_tdata,
    input  logic                                  i_s_tlast,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // keep, box_index, store_full, zero padding
    output logic [gibs_pkg::OUT_DATA_W-1:0]       o_m_tdata,
    output logic                                  o_m_tlast,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [gibs_pkg::THR_W-1:0]            i_cfg_data
);

    localparam int KC_W = $clog2(MAX_KEPT + 1);
    localparam int BC_W = $clog2(MAX_BOXES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT
    } t_state;

    t_state                                r_state;
    logic                                  r_start;
    gibs_pkg::t_box                        r_cand;
    logic [gibs_pkg::AREA_W-1:0]           r_area;
    logic                                  r_last;
    logic                                  r_sup_fin;
    logic [KC_W-1:0]                       r_kept_cnt;
    logic [BC_W-1:0]                       r_box_cnt;
    logic [gibs_pkg::THR_W-1:0]            r_thr;
    logic                                  r_m_valid;
    logic [gibs_pkg::OUT_DATA_W-1:0]       r_m_data;
    logic                                  r_m_last;

    gibs_pkg::t_flow                       w_flow [MAX_KEPT+1];
    logic [MAX_KEPT:0]                     w_vld_vec;
    gibs_pkg::t_box                        w_in_box;
    gibs_pkg::t_flow                       w_tail;
    logic                                  w_sup_tail;
    logic                                  w_out_free;
    logic                                  w_commit;
    logic                                  w_survive;
    logic                                  w_full;
    logic                                  w_keep;

    always_comb begin
        w_in_box.x = i_s_tdata[12:0];
        w_in_box.y = i_s_tdata[25:13];
        w_in_box.w = i_s_tdata[37:26];
        w_in_box.h = i_s_tdata[49:38];
    end

    always_comb begin
        w_flow[0].vld   = r_start;
        w_flow[0].cand  = r_cand;
        w_flow[0].area  = r_area;
        w_flow[0].sup   = 1'b0;
        w_flow[0].act   = 1'b0;
        w_flow[0].inter = '0;
        w_flow[0].uni   = '0;
    end

    assign w_tail     = w_flow[MAX_KEPT];
    assign w_sup_tail = w_tail.sup
                      | (w_tail.act & gibs_pkg::iou_over(w_tail.inter, w_tail.uni, r_thr));
    assign w_out_free = !r_m_valid || i_m_tready;
    assign w_commit   = (r_state == S_WAIT) && w_out_free;
    assign w_survive  = !r_sup_fin;
    assign w_full     = w_survive && (r_kept_cnt == KC_W'(MAX_KEPT));
    assign w_keep     = w_survive && !w_full;

    for (genvar k = 0; k < MAX_KEPT; k++) begin : g_cell
        gibs_cell #(
            .CNT_W (KC_W),
            .IDX   (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_thr      (r_thr),
            .i_kept_cnt (r_kept_cnt),
            .i_wr_en    (w_commit && w_keep),
            .i_wr_box   (r_cand),
            .i_wr_area  (r_area),
            .i_flow     (w_flow[k]),
            .o_flow     (w_flow[k+1])
        );
    end

    for (genvar k = 0; k <= MAX_KEPT; k++) begin : g_vld
        assign w_vld_vec[k] = w_flow[k].vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_start    <= 1'b0;
            r_m_valid  <= 1'b0;
            r_kept_cnt <= '0;
            r_box_cnt  <= '0;
            r_thr      <= gibs_pkg::THR_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            r_start <= (r_state == S_IDLE) && i_s_tvalid;
            if (w_commit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_cand  <= w_in_box;
                        r_area  <= gibs_pkg::AREA_W'(w_in_box.w)
                                 * gibs_pkg::AREA_W'(w_in_box.h);
                        r_last  <= i_s_tlast;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_tail.vld) begin
                        r_sup_fin <= w_sup_tail;
                        r_state   <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (w_out_free) begin
                        r_m_data  <= {gibs_pkg::OUT_PAD_W'(0), w_full,
                                      gibs_pkg::IDX_W'(r_box_cnt), w_keep};
                        r_m_last  <= r_last;
                        if (r_last) begin
                            r_kept_cnt <= '0;
                            r_box_cnt  <= '0;
                        end else begin
                            if (w_keep) begin
                                r_kept_cnt <= r_kept_cnt + 1'b1;
                            end
                            r_box_cnt <= (r_box_cnt == BC_W'(MAX_BOXES - 1)) ? '0
                                       : r_box_cnt + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;
    assign o_m_tlast   = r_m_last;

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld_vec))
        else $error("More than one box is in flight in the cell row.");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (w_vld_vec == '0))
        else $error("Input is ready while a box is still in the cell row.");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept_cnt <= KC_W'(MAX_KEPT))
        else $error("Kept count exceeds the number of cells.");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_last) |=> ((r_kept_cnt == '0) && (r_box_cnt == '0)))
        else $error("End of frame did not clear the counters.");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[gibs_pkg::IDX_W+1]))
        else $error("A result is flagged both kept and store full.");

endmodule
